[design/kfq_pkg.sv]
package kfq_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 32;
   localparam int HELD_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_APPEND     = 2'd0,
      KIND_REMOVE_HEAD = 2'd1,
      KIND_SEARCH     = 2'd2,
      KIND_REMOVE_KEY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // write and shift never assert together
   typedef struct packed {
      logic write;
      logic shift;
   } cell_cmd_type;

endpackage

[design/keyed_fifo_queue_core.sv]
// Channel   Direction  Handshake             Fields
// req       in         req_valid/req_stall   kind, key, payload
// rsp       out        rsp_valid/rsp_stall   status, found_key, found_payload, held, now_empty
//
// A request is decided in the cycle it is accepted; its response shows in the
// next cycle from the output register. One request per cycle while rsp_stall is low.
// All cells compare against the request key at once; a removal shifts the cells
// above the hit down by one in the same edge.
// Reset (synchronous) empties the queue; cell contents are left as they are.
// While a response is held by rsp_stall, req_stall is raised.
module keyed_fifo_queue_core
   import kfq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [KEY_BITS-1:0]  req_key,
   input  logic [DATA_BITS-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [KEY_BITS-1:0]  rsp_found_key,
   output logic [DATA_BITS-1:0] rsp_found_payload,
   output logic [HELD_BITS-1:0] rsp_held,
   output logic                 rsp_now_empty
);

   logic [HELD_BITS-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [KEY_BITS-1:0]  found_key_ff, found_key_in;
   logic [DATA_BITS-1:0] found_payload_ff, found_payload_in;

   logic [KEY_BITS-1:0]  cell_key     [DEPTH+1];
   logic [DATA_BITS-1:0] cell_payload [DEPTH+1];
   cell_cmd_type         cell_cmd     [DEPTH];
   logic [DEPTH-1:0]     match, occupied, hit, first_hit, sel, shift_en, write_en;

   logic     accept, empty, full, found_any;
   kind_type kind;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign kind      = kind_type'(req_kind);
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == HELD_BITS'(DEPTH));

   // past-the-end neighbor of the top cell
   assign cell_key[DEPTH]     = '0;
   assign cell_payload[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i]       = (HELD_BITS'(i) < count_ff);
      assign cell_cmd[i].write = write_en[i];
      assign cell_cmd[i].shift = shift_en[i];

      kfq_cell u_cell (
         .clock        (clock),
         .cmd          (cell_cmd[i]),
         .new_key      (req_key),
         .new_payload  (req_payload),
         .next_key     (cell_key[i+1]),
         .next_payload (cell_payload[i+1]),
         .search_key   (req_key),
         .key          (cell_key[i]),
         .payload      (cell_payload[i]),
         .match        (match[i])
      );
   end

   // oldest hit: isolate lowest set bit; cells at or above it shift on removal
   assign hit       = match & occupied;
   assign first_hit = hit & (~hit + DEPTH'(1));
   assign found_any = |hit;

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      sel       = '0;
      shift_en  = '0;
      write_en  = '0;
      if (accept) begin
         priority if (kind == KIND_APPEND) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  write_en[i] = (count_ff == HELD_BITS'(i));
               end
               count_in = count_ff + HELD_BITS'(1);
            end
         end else if (empty) begin
            status_in = STATUS_EMPTY;
         end else if (kind == KIND_REMOVE_HEAD) begin
            sel      = DEPTH'(1);
            shift_en = '1;
            count_in = count_ff - HELD_BITS'(1);
         end else if (!found_any) begin
            status_in = STATUS_NOT_FOUND;
         end else begin
            sel = first_hit;
            if (kind == KIND_REMOVE_KEY) begin
               shift_en = ~(first_hit - DEPTH'(1));
               count_in = count_ff - HELD_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      found_key_in     = '0;
      found_payload_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_key_in     = found_key_in     | (sel[i] ? cell_key[i]     : '0);
         found_payload_in = found_payload_in | (sel[i] ? cell_payload[i] : '0);
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff        <= status_in;
         found_key_ff     <= found_key_in;
         found_payload_ff <= found_payload_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found_key     = found_key_ff;
   assign rsp_found_payload = found_payload_ff;
   assign rsp_held          = count_ff;
   assign rsp_now_empty     = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HELD_BITS'(DEPTH))
      else $error("fill count beyond depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> (count_ff == HELD_BITS'(DEPTH)))
      else $error("full status while queue not full");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_OK) |-> (found_key_ff == '0 && found_payload_ff == '0))
      else $error("entry returned on failed request");

endmodule

[design/kfq_cell.sv]
module kfq_cell
   import kfq_pkg::*;
(
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic [KEY_BITS-1:0]  new_key,
   input  logic [DATA_BITS-1:0] new_payload,
   input  logic [KEY_BITS-1:0]  next_key,
   input  logic [DATA_BITS-1:0] next_payload,
   input  logic [KEY_BITS-1:0]  search_key,
   output logic [KEY_BITS-1:0]  key,
   output logic [DATA_BITS-1:0] payload,
   output logic                 match
);

   logic [KEY_BITS-1:0]  key_ff;
   logic [DATA_BITS-1:0] payload_ff;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         key_ff     <= new_key;
         payload_ff <= new_payload;
      end else if (cmd.shift) begin
         // take the younger neighbor's entry
         key_ff     <= next_key;
         payload_ff <= next_payload;
      end
   end

   assign key     = key_ff;
   assign payload = payload_ff;
   assign match   = (key_ff == search_key);

endmodule

[dv/keyed_fifo_queue_core_test.sv]
`timescale 1ns / 1ps

module keyed_fifo_queue_core_test;
   import kfq_pkg::*;

   localparam int RANDOM_REQUESTS = 1000;
   localparam int STALL_PERCENT   = 27;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CALM_FROM       = 300;
   localparam int CALM_TO         = 600;

   typedef struct {
      kind_type             kind;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] payload;
   } request_type;

   typedef struct {
      logic [1:0]           status;
      logic [KEY_BITS-1:0]  found_key;
      logic [DATA_BITS-1:0] found_payload;
      logic [HELD_BITS-1:0] held;
      logic                 now_empty;
   } response_type;

   typedef struct {
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] payload;
   } entry_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_kind = KIND_APPEND;
   logic [KEY_BITS-1:0]  req_key = '0;
   logic [DATA_BITS-1:0] req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [KEY_BITS-1:0]  rsp_found_key;
   logic [DATA_BITS-1:0] rsp_found_payload;
   logic [HELD_BITS-1:0] rsp_held;
   logic                 rsp_now_empty;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   entry_type    queue_contents[$];
   int           requests_taken = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   logic         calm;

   keyed_fifo_queue_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_payload (rsp_found_payload),
      .rsp_held          (rsp_held),
      .rsp_now_empty     (rsp_now_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign calm = requests_taken >= CALM_FROM && requests_taken < CALM_TO;

   // applies one request to the shadow queue and returns the response it yields
   function automatic response_type apply_queue_op(kind_type kind, logic [KEY_BITS-1:0] key,
                                                   logic [DATA_BITS-1:0] payload);
      response_type r;
      entry_type    e;
      int           hit;
      r = '{status: STATUS_OK, found_key: '0, found_payload: '0, held: '0, now_empty: 1'b0};
      hit = -1;
      if (kind == KIND_APPEND) begin
         if (queue_contents.size() >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            e.key = key;
            e.payload = payload;
            queue_contents.push_back(e);
         end
      end else if (queue_contents.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else if (kind == KIND_REMOVE_HEAD) begin
         e = queue_contents.pop_front();
         r.found_key = e.key;
         r.found_payload = e.payload;
      end else begin
         for (int i = 0; i < queue_contents.size() && hit < 0; i++)
            if (queue_contents[i].key == key) hit = i;
         if (hit < 0) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            r.found_key = queue_contents[hit].key;
            r.found_payload = queue_contents[hit].payload;
            if (kind == KIND_REMOVE_KEY) queue_contents.delete(hit);
         end
      end
      r.held = HELD_BITS'(queue_contents.size());
      r.now_empty = queue_contents.size() == 0;
      return r;
   endfunction

   task automatic add_request(kind_type kind, logic [KEY_BITS-1:0] key,
                              logic [DATA_BITS-1:0] payload);
      request_type q;
      q.kind = kind;
      q.key = key;
      q.payload = payload;
      pending_requests.push_back(q);
   endtask

   task automatic report_mismatch(string what, response_type exp, response_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected status %0d key %h payload %h held %0d empty %b,",
                  $realtime, what, exp.status, exp.found_key, exp.found_payload, exp.held,
                  exp.now_empty,
                  " got status %0d key %h payload %h held %0d empty %b",
                  got.status, got.found_key, got.found_payload, got.held, got.now_empty);
   endtask

   // request driver
   always @(posedge clock) begin : drive
      request_type q;
      logic        taken;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !taken) begin
         // held request stays as is
      end else if (pending_requests.size() > 0 &&
                   (calm || $urandom_range(99) >= STALL_PERCENT)) begin
         q = pending_requests.pop_front();
         req_valid <= 1'b1;
         req_kind <= q.kind;
         req_key <= q.key;
         req_payload <= q.payload;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < STALL_PERCENT);
   end

   // monitor: predicts on accepted requests, checks accepted responses
   always @(posedge clock) begin : observe
      response_type got, exp;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(apply_queue_op(kind_type'(req_kind), req_key,
                                                        req_payload));
            requests_taken <= requests_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.found_key = rsp_found_key;
            got.found_payload = rsp_found_payload;
            got.held = rsp_held;
            got.now_empty = rsp_now_empty;
            if (expected_responses.size() == 0) begin
               exp = '{status: 'x, found_key: 'x, found_payload: 'x, held: 'x, now_empty: 'x};
               report_mismatch("unexpected response", exp, got);
            end else begin
               exp = expected_responses.pop_front();
               if (got.status !== exp.status || got.found_key !== exp.found_key ||
                   got.found_payload !== exp.found_payload || got.held !== exp.held ||
                   got.now_empty !== exp.now_empty)
                  report_mismatch("response mismatch", exp, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("keyed_fifo_queue_core_test failed");
            $finish;
         end
      end
   end

   initial begin
      logic [KEY_BITS-1:0] corner_keys[4];
      logic [KEY_BITS-1:0] key_pool[8];
      int unsigned         append_pct;
      int unsigned         roll;
      kind_type            kind;
      logic [KEY_BITS-1:0] key;

      corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

      // removals and lookups on an empty queue
      add_request(KIND_REMOVE_HEAD, 32'h0000_0000, 32'hFFFF_FFFF);
      add_request(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
      add_request(KIND_REMOVE_KEY, 32'h0000_0000, 32'h0000_0000);
      // fill to capacity with repeated keys, so oldest-match order matters
      for (int i = 0; i < DEPTH; i++)
         add_request(KIND_APPEND, corner_keys[i % 4],
                     i == 0 ? 32'h0000_0000 : i == 1 ? 32'hFFFF_FFFF : $urandom);
      add_request(KIND_APPEND, 32'h1234_5678, 32'hDEAD_BEEF);      // refused, full
      add_request(KIND_SEARCH, 32'h5A5A_5A5A, 32'h0);
      add_request(KIND_SEARCH, 32'h0000_0001, 32'h0);              // miss
      add_request(KIND_REMOVE_KEY, 32'hA5A5_A5A5, 32'h0);          // hit mid-queue
      add_request(KIND_REMOVE_KEY, 32'h0000_0001, 32'h0);          // miss
      add_request(KIND_REMOVE_HEAD, 32'h0, 32'hFFFF_FFFF);

      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) key_pool[i] = $urandom;

      // phases of 50 requests sweep the fill level between empty and full
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         case ((i / 50) % 3)
            0:       append_pct = 75;
            1:       append_pct = 45;
            default: append_pct = 15;
         endcase
         roll = $urandom_range(99);
         if (roll < append_pct) begin
            kind = KIND_APPEND;
         end else begin
            roll = $urandom_range(99);
            kind = roll < 30 ? KIND_REMOVE_HEAD : roll < 65 ? KIND_SEARCH : KIND_REMOVE_KEY;
         end
         key = $urandom_range(99) < 80 ? key_pool[$urandom_range(7)] : $urandom;
         add_request(kind, key, $urandom);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_responses.size() == 0)
         $display("keyed_fifo_queue_core_test passed");
      else
         $display("keyed_fifo_queue_core_test failed");
      $finish;
   end

endmodule

[keyed_fifo_queue_core.f]
design/kfq_pkg.sv
design/kfq_cell.sv
design/keyed_fifo_queue_core.sv
dv/keyed_fifo_queue_core_test.sv
